// ===== design/rcbu_pkg.sv =====
// Shared constants and item types for the RC channel bit unpacker.
`default_nettype none

package rcbu_pkg;

  // Subset config byte layout and legacy frame size
  localparam int unsigned START_FIELD_BITS = 5;
  localparam int unsigned WIDTH_FIELD_BITS = 2;
  localparam int unsigned LEGACY_CHANNELS  = 16;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned VALUE_W  = 13;
  localparam int unsigned CWIDTH_W = 4;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned BUF_W    = 20;
  localparam int unsigned HELD_W   = 5;

  // Narrowest channel and the most bits that can sit in the buffer before a merge
  localparam logic [CWIDTH_W-1:0] BASE_WIDTH = 4'd10;
  localparam logic [HELD_W-1:0]   HELD_MAX   = 5'd12;
  localparam logic [CODE_W-1:0]   LEGACY_CODE = 2'd1;

  // Masks for the config byte fields
  localparam logic [BYTE_W-1:0] START_MASK = 8'((1 << START_FIELD_BITS) - 1);
  localparam logic [BYTE_W-1:0] WIDTH_MASK = 8'((1 << WIDTH_FIELD_BITS) - 1);
  localparam logic [INDEX_W-1:0] LEGACY_LIMIT = 7'(LEGACY_CHANNELS);

  // One input item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              subset_frame;
    logic              start_of_frame;
    logic              end_of_frame;
  } rcbu_item_t;

  // One result item
  typedef struct packed {
    logic                channel_valid;
    logic [INDEX_W-1:0]  channel_index;
    logic [VALUE_W-1:0]  channel_value;
    logic [CWIDTH_W-1:0] channel_width;
    logic                frame_end;
  } rcbu_result_t;

endpackage

`default_nettype wire

// ===== design/rc_channel_bit_unpacker.sv =====
// Top level of the RC channel bit unpacker: stream ports and result register.
//
// Usage:
//   The slave channel takes one payload byte of a CRC-checked RC frame per
//   item. s_tuser marks a subset frame and the first byte of a frame; s_tlast
//   marks the last byte. The master channel gives at most one result per
//   input byte: a decoded channel (m_tuser high) with its index, value and
//   width, or, on a last byte that completes no channel, an end marker with
//   m_tuser low. m_tlast is high on the result caused by a frame's last byte.
//   Bytes that complete no channel and are not last give no result.
// Timing:
//   One byte per cycle sustained. A result appears in the cycle after its
//   byte is taken, from a single output register fed by the merge-and-split
//   step. s_tready is high while that register is empty or being read, so a
//   new byte is taken in the same cycle as the previous result leaves.
//   When the receiver stalls, the result holds and s_tready drops.
// Reset:
//   rst (synchronous, active high) empties the output register and starts
//   in legacy decoding from channel 0 at eleven bits.
`default_nettype none

module rc_channel_bit_unpacker
  import rcbu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] payload_byte
  input  wire logic [1:0]  s_tuser,   // [0] subset_frame, [1] start_of_frame
  input  wire logic        s_tlast,   // end_of_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [6:0] channel_index, [19:7] channel_value,
                                      // [23:20] channel_width
  output logic [0:0]       m_tuser,   // [0] channel_valid
  output logic             m_tlast    // frame_end
);

  logic         accept;
  rcbu_item_t   item;
  logic         has_result;
  rcbu_result_t result;
  rcbu_result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign item.payload_byte   = s_tdata;
  assign item.subset_frame   = s_tuser[0];
  assign item.start_of_frame = s_tuser[1];
  assign item.end_of_frame   = s_tlast;

  rcbu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= has_result;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {out_reg.channel_width, out_reg.channel_value, out_reg.channel_index};
  assign m_tuser = out_reg.channel_valid;
  assign m_tlast = out_reg.frame_end;

  // A result without a channel is only ever a frame end
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result without frame end");

  // A result without a channel carries zero index and value
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[19:0] == '0)
    else $error("empty result carries data");

  // Width is always one of the four encodable widths
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:20] >= BASE_WIDTH && m_tdata[23:20] <= 4'd13)
    else $error("channel width out of range");

endmodule

`default_nettype wire

// ===== design/rcbu_core.sv =====
// Frame state and the per-byte merge, split and emit step.
`default_nettype none

module rcbu_core
  import rcbu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire rcbu_item_t   item,
  output logic              has_result,
  output rcbu_result_t      result
);

  logic [BUF_W-1:0]   bit_buffer, bit_buffer_next;
  logic [HELD_W-1:0]  bits_held, bits_held_next;
  logic [INDEX_W-1:0] next_channel, next_channel_next;
  logic [CODE_W-1:0]  width_code, width_code_next;
  logic               subset_mode, subset_mode_next;
  logic               awaiting_header, awaiting_header_next;

  logic [BUF_W-1:0]    buf_sof, merged;
  logic [HELD_W-1:0]   held_sof, held_clamp, held_sum;
  logic [INDEX_W-1:0]  chan_sof;
  logic [CODE_W-1:0]   wfield;
  logic [CWIDTH_W-1:0] chan_w, width_out;
  logic [VALUE_W-1:0]  val_mask;
  logic                emit;
  logic [VALUE_W-1:0]  emit_value;
  logic [INDEX_W-1:0]  emit_index;

  // Start byte restarts the frame; then header, data or ignored byte
  always_comb begin
    buf_sof              = item.start_of_frame ? '0 : bit_buffer;
    held_sof             = item.start_of_frame ? '0 : bits_held;
    chan_sof             = item.start_of_frame ? '0 : next_channel;
    subset_mode_next     = item.start_of_frame ? item.subset_frame : subset_mode;
    awaiting_header_next = item.start_of_frame ? item.subset_frame : awaiting_header;
    width_code_next      = (item.start_of_frame && !item.subset_frame) ? LEGACY_CODE
                                                                       : width_code;
    bit_buffer_next      = buf_sof;
    bits_held_next       = held_sof;
    next_channel_next    = chan_sof;
    wfield               = CODE_W'((item.payload_byte >> START_FIELD_BITS) & WIDTH_MASK);
    held_clamp           = (held_sof > HELD_MAX) ? HELD_MAX : held_sof;
    merged               = buf_sof | (BUF_W'(item.payload_byte) << held_clamp);
    held_sum             = held_clamp + HELD_W'(BYTE_W);
    chan_w               = BASE_WIDTH + CWIDTH_W'(width_code_next);
    val_mask             = {VALUE_W{1'b1}} >> (CWIDTH_W'(VALUE_W) - chan_w);
    emit                 = 1'b0;
    emit_value           = '0;
    emit_index           = '0;

    if (subset_mode_next && awaiting_header_next) begin
      // Config byte: start channel and width code
      next_channel_next    = INDEX_W'(item.payload_byte & START_MASK);
      width_code_next      = wfield;
      awaiting_header_next = 1'b0;
    end else if (subset_mode_next || (chan_sof < LEGACY_LIMIT)) begin
      // Data byte: merge and emit at most one channel
      bit_buffer_next = merged;
      bits_held_next  = held_sum;
      if (held_sum >= HELD_W'(chan_w)) begin
        emit              = 1'b1;
        emit_value        = merged[VALUE_W-1:0] & val_mask;
        emit_index        = chan_sof;
        bit_buffer_next   = merged >> chan_w;
        bits_held_next    = held_sum - HELD_W'(chan_w);
        next_channel_next = chan_sof + INDEX_W'(1);
      end
    end

    // Leftover bits are dropped at frame end
    if (item.end_of_frame) begin
      bit_buffer_next = '0;
      bits_held_next  = '0;
    end

    width_out = BASE_WIDTH + CWIDTH_W'(width_code_next);
  end

  assign has_result           = emit || item.end_of_frame;
  assign result.channel_valid = emit;
  assign result.channel_index = emit_index;
  assign result.channel_value = emit_value;
  assign result.channel_width = width_out;
  assign result.frame_end     = item.end_of_frame;

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer      <= '0;
      bits_held       <= '0;
      next_channel    <= '0;
      width_code      <= LEGACY_CODE;
      subset_mode     <= 1'b0;
      awaiting_header <= 1'b0;
    end else if (accept) begin
      bit_buffer      <= bit_buffer_next;
      bits_held       <= bits_held_next;
      next_channel    <= next_channel_next;
      width_code      <= width_code_next;
      subset_mode     <= subset_mode_next;
      awaiting_header <= awaiting_header_next;
    end
  end

  // Buffer never holds a whole channel between items
  a_held_bound: assert property (@(posedge clk) disable iff (rst) bits_held <= HELD_MAX)
    else $error("bits_held above a channel's worth");

  // Frame end empties the buffer
  a_eof_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_frame |=> bits_held == '0 && bit_buffer == '0)
    else $error("buffer not cleared at frame end");

  // Legacy frames stay at eleven bits
  a_legacy_width: assert property (@(posedge clk) disable iff (rst)
    !subset_mode |-> width_code == LEGACY_CODE)
    else $error("legacy width code changed");

endmodule

`default_nettype wire
